/* sv/grbe_pkg.sv */
// shared types, constants and microcode rom for the gyro rate bias ema filter
package grbe_pkg;

  localparam int DEF_MAX_CALIB_SAMPLES = 64;
  localparam int DEF_FRAC_BITS         = 8;

  localparam int RAW_W    = 16;
  localparam int RATE_W   = 25;
  localparam int BIAS_W   = 24;
  localparam int CNT_W    = 16;
  localparam int ALPHA_W  = 16;
  localparam int NCAL_W   = 7;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int TGT_W    = 9;
  localparam int DIFF_W   = RATE_W + 1;
  localparam int PROD_W   = DIFF_W + ALPHA_W;
  localparam int UPC_W    = 5;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd19661;
  localparam logic [NCAL_W-1:0]  NCAL_RESET  = 7'd64;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NCAL  = 1'b1;

  localparam logic [1:0] OPC_INIT   = 2'd0;
  localparam logic [1:0] OPC_CAL    = 2'd1;
  localparam logic [1:0] OPC_SAMPLE = 2'd2;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_EMIT,
    DP_LATCH,
    DP_RATE,
    DP_DIFF,
    DP_MUL,
    DP_ACC,
    DP_INIT,
    DP_CAL_START,
    DP_CACC,
    DP_FIN,
    DP_DIV_LOAD,
    DP_DIV_STEP,
    DP_DIV_END,
    DP_ERR,
    DP_CLR
  } dp_op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_OUT_BUSY,
    C_NO_INPUT,
    C_OP_INIT,
    C_OP_CAL,
    C_OP_NOT_SMP,
    C_CAL_ACTIVE,
    C_NOT_PRESENT,
    C_NOT_READ_OK,
    C_NOT_DEV_OK,
    C_CAL_MORE,
    C_TAKEN_ZERO,
    C_DIV_MORE
  } cond_sel_t;

  typedef struct packed {
    dp_op_t           op;
    cond_sel_t        cond;
    logic [UPC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic out_busy;
    logic in_valid;
    logic op_init;
    logic op_cal;
    logic op_smp;
    logic calib_active;
    logic present;
    logic read_ok;
    logic dev_ok;
    logic cal_more;
    logic taken_zero;
    logic div_more;
  } ucond_t;

  localparam logic [UPC_W-1:0] UA_EMIT     = 5'd0;
  localparam logic [UPC_W-1:0] UA_FETCH    = 5'd1;
  localparam logic [UPC_W-1:0] UA_DEC0     = 5'd2;
  localparam logic [UPC_W-1:0] UA_DEC1     = 5'd3;
  localparam logic [UPC_W-1:0] UA_DEC2     = 5'd4;
  localparam logic [UPC_W-1:0] UA_SMP0     = 5'd5;
  localparam logic [UPC_W-1:0] UA_SMP1     = 5'd6;
  localparam logic [UPC_W-1:0] UA_SMP2     = 5'd7;
  localparam logic [UPC_W-1:0] UA_RATE     = 5'd8;
  localparam logic [UPC_W-1:0] UA_DIFF     = 5'd9;
  localparam logic [UPC_W-1:0] UA_MUL      = 5'd10;
  localparam logic [UPC_W-1:0] UA_ACC      = 5'd11;
  localparam logic [UPC_W-1:0] UA_INIT     = 5'd12;
  localparam logic [UPC_W-1:0] UA_CAL      = 5'd13;
  localparam logic [UPC_W-1:0] UA_CAL_GO   = 5'd14;
  localparam logic [UPC_W-1:0] UA_CSMP     = 5'd15;
  localparam logic [UPC_W-1:0] UA_CACC     = 5'd16;
  localparam logic [UPC_W-1:0] UA_CCHK     = 5'd17;
  localparam logic [UPC_W-1:0] UA_FIN      = 5'd18;
  localparam logic [UPC_W-1:0] UA_DIV_LD   = 5'd19;
  localparam logic [UPC_W-1:0] UA_DIV_STEP = 5'd20;
  localparam logic [UPC_W-1:0] UA_DIV_END  = 5'd21;
  localparam logic [UPC_W-1:0] UA_CERR     = 5'd22;
  localparam logic [UPC_W-1:0] UA_ERR      = 5'd23;
  localparam logic [UPC_W-1:0] UA_CLR      = 5'd24;

  function automatic ucode_t grbe_urom(input logic [UPC_W-1:0] addr);
    ucode_t w;
    unique case (addr)
      UA_EMIT:     w = '{DP_EMIT,      C_OUT_BUSY,    UA_EMIT};
      UA_FETCH:    w = '{DP_LATCH,     C_NO_INPUT,    UA_FETCH};
      UA_DEC0:     w = '{DP_NOP,       C_OP_INIT,     UA_INIT};
      UA_DEC1:     w = '{DP_NOP,       C_OP_CAL,      UA_CAL};
      UA_DEC2:     w = '{DP_NOP,       C_OP_NOT_SMP,  UA_EMIT};
      UA_SMP0:     w = '{DP_NOP,       C_CAL_ACTIVE,  UA_CSMP};
      UA_SMP1:     w = '{DP_NOP,       C_NOT_PRESENT, UA_CLR};
      UA_SMP2:     w = '{DP_NOP,       C_NOT_READ_OK, UA_ERR};
      UA_RATE:     w = '{DP_RATE,      C_NEVER,       UA_EMIT};
      UA_DIFF:     w = '{DP_DIFF,      C_NEVER,       UA_EMIT};
      UA_MUL:      w = '{DP_MUL,       C_NEVER,       UA_EMIT};
      UA_ACC:      w = '{DP_ACC,       C_ALWAYS,      UA_EMIT};
      UA_INIT:     w = '{DP_INIT,      C_NOT_DEV_OK,  UA_ERR};
      UA_CAL:      w = '{DP_NOP,       C_NOT_PRESENT, UA_CLR};
      UA_CAL_GO:   w = '{DP_CAL_START, C_ALWAYS,      UA_EMIT};
      UA_CSMP:     w = '{DP_NOP,       C_NOT_READ_OK, UA_CERR};
      UA_CACC:     w = '{DP_CACC,      C_NEVER,       UA_EMIT};
      UA_CCHK:     w = '{DP_NOP,       C_CAL_MORE,    UA_EMIT};
      UA_FIN:      w = '{DP_FIN,       C_TAKEN_ZERO,  UA_EMIT};
      UA_DIV_LD:   w = '{DP_DIV_LOAD,  C_NEVER,       UA_EMIT};
      UA_DIV_STEP: w = '{DP_DIV_STEP,  C_DIV_MORE,    UA_DIV_STEP};
      UA_DIV_END:  w = '{DP_DIV_END,   C_ALWAYS,      UA_EMIT};
      UA_CERR:     w = '{DP_ERR,       C_ALWAYS,      UA_FIN};
      UA_ERR:      w = '{DP_ERR,       C_ALWAYS,      UA_EMIT};
      UA_CLR:      w = '{DP_CLR,       C_ALWAYS,      UA_EMIT};
      default:     w = '{DP_NOP,       C_ALWAYS,      UA_FETCH};
    endcase
    return w;
  endfunction

endpackage

/* sv/grbe_seq.sv */
// microcode sequencer: step counter, control rom and branch condition select
module grbe_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  grbe_pkg::ucond_t  cond_i,
  output grbe_pkg::ucode_t  uword_o
);
  import grbe_pkg::*;

  logic [UPC_W-1:0] pc_r;
  logic [UPC_W-1:0] pc_nxt;
  ucode_t           uword;
  logic             jump;

  assign uword   = grbe_urom(pc_r);
  assign uword_o = uword;

  always_comb begin
    unique case (uword.cond)
      C_NEVER:       jump = 1'b0;
      C_ALWAYS:      jump = 1'b1;
      C_OUT_BUSY:    jump = cond_i.out_busy;
      C_NO_INPUT:    jump = ~cond_i.in_valid;
      C_OP_INIT:     jump = cond_i.op_init;
      C_OP_CAL:      jump = cond_i.op_cal;
      C_OP_NOT_SMP:  jump = ~cond_i.op_smp;
      C_CAL_ACTIVE:  jump = cond_i.calib_active;
      C_NOT_PRESENT: jump = ~cond_i.present;
      C_NOT_READ_OK: jump = ~cond_i.read_ok;
      C_NOT_DEV_OK:  jump = ~cond_i.dev_ok;
      C_CAL_MORE:    jump = cond_i.cal_more;
      C_TAKEN_ZERO:  jump = cond_i.taken_zero;
      C_DIV_MORE:    jump = cond_i.div_more;
      default:       jump = 1'b1;
    endcase
  end

  assign pc_nxt = jump ? uword.target : pc_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= UA_FETCH;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

/* sv/gyro_rate_bias_ema_filter_core.sv */
// top level: gyro z bias calibration and exponential average datapath
// Each beat on the input channel is one command (init, start calibration, gyro sample
// or unused opcode) and gives exactly one result beat with the state after it.
// A small microprogram walks a shared datapath, so the block takes one item at a
// time and takes no new item until the result of the current one is loaded into
// the output register. The sample that closes a calibration run also runs the
// bias divider, a restoring unit retiring one quotient bit per cycle over 16 +
// clog2(MAX_CALIB_SAMPLES + 1) + FRAC_BITS bits (31 by default).
// A finished result sits in an output register, so the next item can be taken
// while it waits. Configuration writes are always ready and are meant for idle time.
module gyro_rate_bias_ema_filter_core #(
  parameter int MAX_CALIB_SAMPLES = grbe_pkg::DEF_MAX_CALIB_SAMPLES,
  parameter int FRAC_BITS         = grbe_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [grbe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [grbe_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_opcode,
  input  logic                              in_device_ok,
  input  logic signed [grbe_pkg::RAW_W-1:0] in_raw_sample,
  input  logic                              in_read_ok,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [grbe_pkg::RATE_W-1:0] out_rate_q8,
  output logic signed [grbe_pkg::RATE_W-1:0] out_filtered_rate_q8,
  output logic signed [grbe_pkg::BIAS_W-1:0] out_bias_q8,
  output logic signed [grbe_pkg::RAW_W-1:0]  out_last_raw,
  output logic                              out_output_valid,
  output logic                              out_device_present,
  output logic                              out_calibrating,
  output logic [grbe_pkg::CNT_W-1:0]        out_errors_seen,
  output logic [grbe_pkg::CNT_W-1:0]        out_samples_taken
);
  import grbe_pkg::*;

  localparam int TK_W   = $clog2(MAX_CALIB_SAMPLES + 1);
  localparam int SUM_W  = RAW_W + TK_W;
  localparam int DVD_W  = SUM_W + FRAC_BITS;
  localparam int QX_W   = (DVD_W > BIAS_W) ? DVD_W : BIAS_W;
  localparam int DCNT_W = $clog2(DVD_W + 1);
  localparam logic [TGT_W-1:0]  MAX_TGT  = TGT_W'(MAX_CALIB_SAMPLES);
  localparam logic [DCNT_W-1:0] DIV_LEN  = DCNT_W'(DVD_W);

  ucode_t uword;
  ucond_t cond;

  // configuration
  logic [ALPHA_W-1:0] alpha_r, alpha_nxt;
  logic [NCAL_W-1:0]  ncal_r, ncal_nxt;

  // latched item
  logic [1:0]              opc_r, opc_nxt;
  logic                    dev_ok_r, dev_ok_nxt;
  logic signed [RAW_W-1:0] raw_r, raw_nxt;
  logic                    rd_ok_r, rd_ok_nxt;

  // architectural state
  logic                     present_r, present_nxt;
  logic                     valid_flag_r, valid_flag_nxt;
  logic                     calib_active_r, calib_active_nxt;
  logic [TK_W-1:0]          calib_taken_r, calib_taken_nxt;
  logic signed [SUM_W-1:0]  calib_sum_r, calib_sum_nxt;
  logic signed [BIAS_W-1:0] bias_r, bias_nxt;
  logic signed [RATE_W-1:0] rate_r, rate_nxt;
  logic signed [RATE_W-1:0] filt_r, filt_nxt;
  logic signed [RAW_W-1:0]  raw_hold_r, raw_hold_nxt;
  logic [CNT_W-1:0]         err_total_r, err_total_nxt;
  logic [CNT_W-1:0]         smp_total_r, smp_total_nxt;

  // working registers
  logic signed [DIFF_W-1:0] diff_r, diff_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [DVD_W-1:0]         dvd_r, dvd_nxt;
  logic [TK_W-1:0]          rem_r, rem_nxt;
  logic [DCNT_W-1:0]        dcnt_r, dcnt_nxt;

  // output register
  logic                     out_valid_r, out_valid_nxt;
  logic signed [RATE_W-1:0] o_rate_r, o_filt_r;
  logic signed [BIAS_W-1:0] o_bias_r;
  logic signed [RAW_W-1:0]  o_raw_r;
  logic                     o_vflag_r, o_present_r, o_calib_r;
  logic [CNT_W-1:0]         o_err_r, o_smp_r;

  logic                     in_acc, out_busy, out_load;
  logic [TGT_W-1:0]         ncal_ext, target;
  logic signed [RATE_W-1:0] raw_ext, rate_calc, filt_step;
  logic signed [PROD_W+1:0] prod_full;
  logic signed [PROD_W-1:0] prod_adj;
  logic [SUM_W-1:0]         sum_mag;
  logic [TK_W:0]            rem_sh, rem_sub;
  logic                     rem_ge;
  logic [QX_W-1:0]          quot_x;
  logic [BIAS_W-1:0]        quot_lo;

  grbe_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .cond_i  (cond),
    .uword_o (uword)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (uword.op != DP_LATCH);
  assign in_acc    = in_valid & ~in_stall;
  assign out_busy  = out_valid_r & out_stall;
  assign out_load  = (uword.op == DP_EMIT) & ~out_busy;

  // calibration target: zero acts as one, saturate at MAX_CALIB_SAMPLES
  assign ncal_ext = TGT_W'(ncal_r);
  always_comb begin
    priority if (ncal_ext == '0) begin
      target = TGT_W'(1);
    end else if (ncal_ext > MAX_TGT) begin
      target = MAX_TGT;
    end else begin
      target = ncal_ext;
    end
  end

  assign cond.out_busy     = out_busy;
  assign cond.in_valid     = in_valid;
  assign cond.op_init      = (opc_r == OPC_INIT);
  assign cond.op_cal       = (opc_r == OPC_CAL);
  assign cond.op_smp       = (opc_r == OPC_SAMPLE);
  assign cond.calib_active = calib_active_r;
  assign cond.present      = present_r;
  assign cond.read_ok      = rd_ok_r;
  assign cond.dev_ok       = dev_ok_r;
  assign cond.cal_more     = (TGT_W'(calib_taken_r) < target);
  assign cond.taken_zero   = (calib_taken_r == '0);
  assign cond.div_more     = (dcnt_r > DCNT_W'(1));

  // datapath arithmetic
  assign raw_ext   = {{(RATE_W-RAW_W){raw_r[RAW_W-1]}}, raw_r};
  assign rate_calc = (raw_ext <<< FRAC_BITS) - {bias_r[BIAS_W-1], bias_r};
  assign prod_full = diff_r * $signed({1'b0, alpha_r});
  // trunc toward zero for the q16 scale
  assign prod_adj  = prod_r + (prod_r[PROD_W-1] ? PROD_W'((1 << ALPHA_W) - 1) : '0);
  assign filt_step = prod_adj[ALPHA_W +: RATE_W];
  assign sum_mag   = calib_sum_r[SUM_W-1] ? SUM_W'(-calib_sum_r) : SUM_W'(calib_sum_r);
  assign rem_sh    = {rem_r, dvd_r[DVD_W-1]};
  assign rem_ge    = (rem_sh >= {1'b0, calib_taken_r});
  assign rem_sub   = rem_sh - {1'b0, calib_taken_r};
  assign quot_x    = QX_W'(dvd_r);
  assign quot_lo   = quot_x[BIAS_W-1:0];

  always_comb begin
    alpha_nxt        = alpha_r;
    ncal_nxt         = ncal_r;
    opc_nxt          = opc_r;
    dev_ok_nxt       = dev_ok_r;
    raw_nxt          = raw_r;
    rd_ok_nxt        = rd_ok_r;
    present_nxt      = present_r;
    valid_flag_nxt   = valid_flag_r;
    calib_active_nxt = calib_active_r;
    calib_taken_nxt  = calib_taken_r;
    calib_sum_nxt    = calib_sum_r;
    bias_nxt         = bias_r;
    rate_nxt         = rate_r;
    filt_nxt         = filt_r;
    raw_hold_nxt     = raw_hold_r;
    err_total_nxt    = err_total_r;
    smp_total_nxt    = smp_total_r;
    diff_nxt         = diff_r;
    prod_nxt         = prod_r;
    dvd_nxt          = dvd_r;
    rem_nxt          = rem_r;
    dcnt_nxt         = dcnt_r;

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ALPHA: alpha_nxt = cfg_data[ALPHA_W-1:0];
        CFG_NCAL:  ncal_nxt  = cfg_data[NCAL_W-1:0];
        default:   alpha_nxt = alpha_r;
      endcase
    end

    unique case (uword.op)
      DP_LATCH: begin
        if (in_acc) begin
          opc_nxt    = in_opcode;
          dev_ok_nxt = in_device_ok;
          raw_nxt    = in_raw_sample;
          rd_ok_nxt  = in_read_ok;
        end
      end
      DP_RATE: begin
        rate_nxt       = rate_calc;
        raw_hold_nxt   = raw_r;
        valid_flag_nxt = 1'b1;
        present_nxt    = 1'b1;
        smp_total_nxt  = smp_total_r + 1'b1;
      end
      DP_DIFF: begin
        diff_nxt = {rate_r[RATE_W-1], rate_r} - {filt_r[RATE_W-1], filt_r};
      end
      DP_MUL: begin
        prod_nxt = prod_full[PROD_W-1:0];
      end
      DP_ACC: begin
        filt_nxt = filt_r + filt_step;
      end
      DP_INIT: begin
        valid_flag_nxt   = 1'b0;
        raw_hold_nxt     = '0;
        rate_nxt         = '0;
        filt_nxt         = '0;
        present_nxt      = dev_ok_r;
        bias_nxt         = '0;
        smp_total_nxt    = '0;
        err_total_nxt    = '0;
        calib_active_nxt = 1'b0;
        calib_taken_nxt  = '0;
        calib_sum_nxt    = '0;
      end
      DP_CAL_START: begin
        valid_flag_nxt   = 1'b0;
        bias_nxt         = '0;
        calib_active_nxt = 1'b1;
        calib_taken_nxt  = '0;
        calib_sum_nxt    = '0;
      end
      DP_CACC: begin
        calib_sum_nxt   = calib_sum_r + {{(SUM_W-RAW_W){raw_r[RAW_W-1]}}, raw_r};
        calib_taken_nxt = calib_taken_r + 1'b1;
      end
      DP_FIN: begin
        calib_active_nxt = 1'b0;
      end
      DP_DIV_LOAD: begin
        dvd_nxt  = {sum_mag, {FRAC_BITS{1'b0}}};
        rem_nxt  = '0;
        dcnt_nxt = DIV_LEN;
      end
      DP_DIV_STEP: begin
        rem_nxt  = rem_ge ? rem_sub[TK_W-1:0] : rem_sh[TK_W-1:0];
        dvd_nxt  = {dvd_r[DVD_W-2:0], rem_ge};
        dcnt_nxt = dcnt_r - 1'b1;
      end
      DP_DIV_END: begin
        bias_nxt       = calib_sum_r[SUM_W-1] ? -quot_lo : quot_lo;
        filt_nxt       = '0;
        rate_nxt       = '0;
        valid_flag_nxt = 1'b1;
      end
      DP_ERR: begin
        err_total_nxt    = err_total_r + 1'b1;
        present_nxt      = 1'b0;
        valid_flag_nxt   = 1'b0;
        raw_hold_nxt     = '0;
        rate_nxt         = '0;
        filt_nxt         = '0;
        calib_active_nxt = 1'b0;
      end
      DP_CLR: begin
        valid_flag_nxt   = 1'b0;
        raw_hold_nxt     = '0;
        rate_nxt         = '0;
        filt_nxt         = '0;
        calib_active_nxt = 1'b0;
      end
      default: begin
        calib_active_nxt = calib_active_r;
      end
    endcase
  end

  always_comb begin
    priority if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r        <= ALPHA_RESET;
      ncal_r         <= NCAL_RESET;
      present_r      <= 1'b0;
      valid_flag_r   <= 1'b0;
      calib_active_r <= 1'b0;
      calib_taken_r  <= '0;
      calib_sum_r    <= '0;
      bias_r         <= '0;
      rate_r         <= '0;
      filt_r         <= '0;
      raw_hold_r     <= '0;
      err_total_r    <= '0;
      smp_total_r    <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      alpha_r        <= alpha_nxt;
      ncal_r         <= ncal_nxt;
      present_r      <= present_nxt;
      valid_flag_r   <= valid_flag_nxt;
      calib_active_r <= calib_active_nxt;
      calib_taken_r  <= calib_taken_nxt;
      calib_sum_r    <= calib_sum_nxt;
      bias_r         <= bias_nxt;
      rate_r         <= rate_nxt;
      filt_r         <= filt_nxt;
      raw_hold_r     <= raw_hold_nxt;
      err_total_r    <= err_total_nxt;
      smp_total_r    <= smp_total_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    opc_r    <= opc_nxt;
    dev_ok_r <= dev_ok_nxt;
    raw_r    <= raw_nxt;
    rd_ok_r  <= rd_ok_nxt;
    diff_r   <= diff_nxt;
    prod_r   <= prod_nxt;
    dvd_r    <= dvd_nxt;
    rem_r    <= rem_nxt;
    dcnt_r   <= dcnt_nxt;
    if (out_load) begin
      o_rate_r    <= rate_r;
      o_filt_r    <= filt_r;
      o_bias_r    <= bias_r;
      o_raw_r     <= raw_hold_r;
      o_vflag_r   <= valid_flag_r;
      o_present_r <= present_r;
      o_calib_r   <= calib_active_r;
      o_err_r     <= err_total_r;
      o_smp_r     <= smp_total_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_rate_q8          = o_rate_r;
  assign out_filtered_rate_q8 = o_filt_r;
  assign out_bias_q8          = o_bias_r;
  assign out_last_raw         = o_raw_r;
  assign out_output_valid     = o_vflag_r;
  assign out_device_present   = o_present_r;
  assign out_calibrating      = o_calib_r;
  assign out_errors_seen      = o_err_r;
  assign out_samples_taken    = o_smp_r;

  a_calib_needs_present: assert property (@(posedge clk) disable iff (!rst_n)
    calib_active_r |-> present_r)
    else $error("calibration active without device present");

  a_taken_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    TGT_W'(calib_taken_r) <= MAX_TGT)
    else $error("calibration sample count beyond limit");

  a_div_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (uword.op == DP_DIV_STEP) |-> (dcnt_r != '0))
    else $error("divider step with exhausted count");

  a_sample_count_flags: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (smp_total_r != $past(smp_total_r)) && (smp_total_r != '0))
      |-> (valid_flag_r && present_r))
    else $error("sample counted without valid output");

endmodule

/* tb/gyro_rate_bias_ema_filter_core_test.sv */
// self-checking testbench for the gyro z bias calibration and ema filter core
`timescale 1ns / 100ps

module gyro_rate_bias_ema_filter_core_test;
  import grbe_pkg::*;

  localparam logic [1:0] OPC_NONE = 2'd3;
  localparam logic signed [RAW_W-1:0] RAW_MAX = 16'sh7fff;
  localparam logic signed [RAW_W-1:0] RAW_MIN = 16'sh8000;
  localparam int PLAN_ROWS = 26;
  localparam int PHASE_ITEMS = 500;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [1:0]               op;
    logic                     dev_ok;
    logic signed [RAW_W-1:0]  raw;
    logic                     read_ok;
  } gyro_cmd_t;

  typedef struct packed {
    logic signed [RATE_W-1:0] rate;
    logic signed [RATE_W-1:0] filtered;
    logic signed [BIAS_W-1:0] bias;
    logic signed [RAW_W-1:0]  last_raw;
    logic                     out_ok;
    logic                     present;
    logic                     calibrating;
    logic [CNT_W-1:0]         errors;
    logic [CNT_W-1:0]         samples;
  } rate_report_t;

  typedef struct packed {
    gyro_cmd_t    cmd;
    logic         typed;
    rate_report_t want;
  } plan_row_t;

  localparam rate_report_t NO_WANT = '0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_opcode = OPC_INIT;
  logic in_device_ok = 1'b0;
  logic signed [RAW_W-1:0] in_raw_sample = '0;
  logic in_read_ok = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [RATE_W-1:0] out_rate_q8;
  logic signed [RATE_W-1:0] out_filtered_rate_q8;
  logic signed [BIAS_W-1:0] out_bias_q8;
  logic signed [RAW_W-1:0] out_last_raw;
  logic out_output_valid;
  logic out_device_present;
  logic out_calibrating;
  logic [CNT_W-1:0] out_errors_seen;
  logic [CNT_W-1:0] out_samples_taken;

  int tx_idle_pct = 31;
  int rx_idle_pct = 62;
  int hold_asks = 0;
  int mismatches = 0;
  rate_report_t expected_reports[$];

  // predictor state and register copies
  logic [ALPHA_W-1:0] alpha_p = ALPHA_RESET;
  logic [NCAL_W-1:0] ncal_p = NCAL_RESET;
  logic present_p = 1'b0;
  logic out_ok_p = 1'b0;
  logic calib_p = 1'b0;
  int unsigned taken_p = 0;
  longint sum_p = 0;
  logic signed [BIAS_W-1:0] bias_p = '0;
  logic signed [RATE_W-1:0] rate_p = '0;
  logic signed [RATE_W-1:0] filt_p = '0;
  logic signed [RAW_W-1:0] raw_p = '0;
  logic [CNT_W-1:0] errs_p = '0;
  logic [CNT_W-1:0] smps_p = '0;

  plan_row_t plan [PLAN_ROWS] = '{
    '{'{OPC_SAMPLE, 1'b0, RAW_MAX, 1'b1}, 1'b1,
      '{25'sd0, 25'sd0, 24'sd0, 16'sd0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0}},
    '{'{OPC_INIT, 1'b0, 16'sd0, 1'b0}, 1'b1,
      '{25'sd0, 25'sd0, 24'sd0, 16'sd0, 1'b0, 1'b0, 1'b0, 16'd1, 16'd0}},
    '{'{OPC_NONE, 1'b1, RAW_MIN, 1'b0}, 1'b1,
      '{25'sd0, 25'sd0, 24'sd0, 16'sd0, 1'b0, 1'b0, 1'b0, 16'd1, 16'd0}},
    '{'{OPC_CAL, 1'b1, RAW_MAX, 1'b1}, 1'b1,
      '{25'sd0, 25'sd0, 24'sd0, 16'sd0, 1'b0, 1'b0, 1'b0, 16'd1, 16'd0}},
    '{'{OPC_INIT, 1'b1, 16'sd0, 1'b0}, 1'b1,
      '{25'sd0, 25'sd0, 24'sd0, 16'sd0, 1'b0, 1'b1, 1'b1, 16'd0, 16'd0}},
    '{'{OPC_SAMPLE, 1'b0, RAW_MIN, 1'b1}, 1'b0, NO_WANT},
    '{'{OPC_CAL, 1'b0, 16'sd0, 1'b0}, 1'b0, NO_WANT},
    '{'{OPC_SAMPLE, 1'b0, RAW_MIN, 1'b1}, 1'b0, NO_WANT},
    '{'{OPC_SAMPLE, 1'b1, RAW_MIN, 1'b1}, 1'b0, NO_WANT},
    '{'{OPC_SAMPLE, 1'b0, RAW_MIN, 1'b1}, 1'b0, NO_WANT},
    '{'{OPC_SAMPLE, 1'b0, RAW_MAX, 1'b1}, 1'b0, NO_WANT},
    '{'{OPC_SAMPLE, 1'b0, RAW_MIN, 1'b1}, 1'b0, NO_WANT},
    '{'{OPC_SAMPLE, 1'b0, RAW_MAX, 1'b1}, 1'b0, NO_WANT},
    '{'{OPC_CAL, 1'b1, 16'sd0, 1'b1}, 1'b0, NO_WANT},
    '{'{OPC_SAMPLE, 1'b0, 16'sd1234, 1'b1}, 1'b0, NO_WANT},
    '{'{OPC_SAMPLE, 1'b0, 16'sd0, 1'b0}, 1'b0, NO_WANT},
    '{'{OPC_SAMPLE, 1'b0, 16'sd5, 1'b1}, 1'b0, NO_WANT},
    '{'{OPC_INIT, 1'b1, 16'sd0, 1'b1}, 1'b0, NO_WANT},
    '{'{OPC_SAMPLE, 1'b0, -16'sd77, 1'b0}, 1'b0, NO_WANT},
    '{'{OPC_INIT, 1'b1, 16'sd0, 1'b1}, 1'b0, NO_WANT},
    '{'{OPC_NONE, 1'b0, 16'sd0, 1'b1}, 1'b0, NO_WANT},
    '{'{OPC_SAMPLE, 1'b0, RAW_MAX, 1'b1}, 1'b0, NO_WANT},
    '{'{OPC_SAMPLE, 1'b0, RAW_MAX, 1'b1}, 1'b0, NO_WANT},
    '{'{OPC_SAMPLE, 1'b0, RAW_MAX, 1'b1}, 1'b0, NO_WANT},
    '{'{OPC_SAMPLE, 1'b0, RAW_MIN, 1'b1}, 1'b0, NO_WANT},
    '{'{OPC_SAMPLE, 1'b0, 16'sd0, 1'b0}, 1'b0, NO_WANT}
  };

  gyro_rate_bias_ema_filter_core u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_opcode            (in_opcode),
    .in_device_ok         (in_device_ok),
    .in_raw_sample        (in_raw_sample),
    .in_read_ok           (in_read_ok),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_rate_q8          (out_rate_q8),
    .out_filtered_rate_q8 (out_filtered_rate_q8),
    .out_bias_q8          (out_bias_q8),
    .out_last_raw         (out_last_raw),
    .out_output_valid     (out_output_valid),
    .out_device_present   (out_device_present),
    .out_calibrating      (out_calibrating),
    .out_errors_seen      (out_errors_seen),
    .out_samples_taken    (out_samples_taken)
  );

  always #1 clk = ~clk;

  function automatic void clear_rate_outputs();
    out_ok_p = 1'b0;
    raw_p = '0;
    rate_p = '0;
    filt_p = '0;
  endfunction

  function automatic void count_read_error();
    errs_p = errs_p + 1'b1;
    present_p = 1'b0;
    clear_rate_outputs();
  endfunction

  function automatic void close_calibration();
    longint quot;
    calib_p = 1'b0;
    if (taken_p > 0) begin
      quot = (sum_p * (longint'(1) << DEF_FRAC_BITS)) / longint'(taken_p);
      bias_p = quot[BIAS_W-1:0];
      filt_p = '0;
      rate_p = '0;
      out_ok_p = 1'b1;
    end
  endfunction

  function automatic void open_calibration();
    if (!present_p) begin
      clear_rate_outputs();
      calib_p = 1'b0;
    end else begin
      out_ok_p = 1'b0;
      bias_p = '0;
      calib_p = 1'b1;
      taken_p = 0;
      sum_p = 0;
    end
  endfunction

  function automatic rate_report_t condition_gyro(gyro_cmd_t c);
    int unsigned goal;
    longint rate_full;
    longint diff;
    longint filt_full;
    logic signed [RATE_W-1:0] rate_new;
    case (c.op)
      OPC_INIT: begin
        clear_rate_outputs();
        present_p = 1'b0;
        bias_p = '0;
        smps_p = '0;
        errs_p = '0;
        calib_p = 1'b0;
        taken_p = 0;
        sum_p = 0;
        if (c.dev_ok) begin
          present_p = 1'b1;
          open_calibration();
        end else begin
          count_read_error();
        end
      end
      OPC_CAL: open_calibration();
      OPC_SAMPLE: begin
        if (calib_p) begin
          goal = ncal_p;
          if (goal == 0) goal = 1;
          if (goal > DEF_MAX_CALIB_SAMPLES) goal = DEF_MAX_CALIB_SAMPLES;
          if (c.read_ok) begin
            sum_p = sum_p + longint'(c.raw);
            taken_p = taken_p + 1;
            if (taken_p >= goal) close_calibration();
          end else begin
            count_read_error();
            close_calibration();
          end
        end else if (!present_p) begin
          clear_rate_outputs();
        end else if (!c.read_ok) begin
          count_read_error();
        end else begin
          rate_full = longint'(c.raw) * (longint'(1) << DEF_FRAC_BITS) - longint'(bias_p);
          rate_new = rate_full[RATE_W-1:0];
          diff = longint'(rate_new) - longint'(filt_p);
          filt_full = longint'(filt_p) + (diff * longint'(alpha_p)) / 65536;
          filt_p = filt_full[RATE_W-1:0];
          rate_p = rate_new;
          raw_p = c.raw;
          out_ok_p = 1'b1;
          present_p = 1'b1;
          smps_p = smps_p + 1'b1;
        end
      end
      default: ;
    endcase
    return '{rate_p, filt_p, bias_p, raw_p, out_ok_p, present_p, calib_p, errs_p, smps_p};
  endfunction

  // random commands shaped as init, calibration run, then a stream of samples
  function automatic gyro_cmd_t pick_gyro_cmd();
    gyro_cmd_t c;
    int roll;
    int sel;
    roll = $urandom_range(99);
    sel = $urandom_range(99);
    c.dev_ok = ($urandom_range(99) < 90);
    c.read_ok = ($urandom_range(999) < (calib_p ? 995 : 950));
    if (sel < 8) c.raw = RAW_MAX;
    else if (sel < 16) c.raw = RAW_MIN;
    else if (sel < 60) c.raw = 16'($urandom_range(1000)) - 16'sd500;
    else c.raw = 16'($urandom);
    if (calib_p) begin
      if (roll < 1) c.op = OPC_CAL;
      else if (roll < 2) c.op = OPC_NONE;
      else c.op = OPC_SAMPLE;
    end else if (!present_p) begin
      if (roll < 60) c.op = OPC_INIT;
      else if (roll < 70) c.op = OPC_CAL;
      else if (roll < 75) c.op = OPC_NONE;
      else c.op = OPC_SAMPLE;
    end else begin
      if (roll < 2) c.op = OPC_INIT;
      else if (roll < 5) c.op = OPC_CAL;
      else if (roll < 8) c.op = OPC_NONE;
      else c.op = OPC_SAMPLE;
    end
    return c;
  endfunction

  task automatic send_gyro_cmd(input gyro_cmd_t c, input logic typed, input rate_report_t want);
    int gap;
    rate_report_t predicted;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= c.op;
    in_device_ok <= c.dev_ok;
    in_raw_sample <= c.raw;
    in_read_ok <= c.read_ok;
    do @(posedge clk); while (in_stall);
    predicted = condition_gyro(c);
    expected_reports.push_back(typed ? want : predicted);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_ALPHA) alpha_p = data;
    else ncal_p = data[NCAL_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  task automatic run_random_phase(input int tx_pct, input int rx_pct,
                                  input logic [CFG_W-1:0] alpha, input logic [CFG_W-1:0] ncal,
                                  input bit squeeze);
    drain_results();
    write_register(CFG_ALPHA, alpha);
    write_register(CFG_NCAL, ncal);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    if (squeeze) hold_asks++;
    repeat (PHASE_ITEMS) send_gyro_cmd(pick_gyro_cmd(), 1'b0, NO_WANT);
  endtask

  // receiver: random stall, plus a long hold-off on request
  initial begin
    int served;
    int hold_left;
    served = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (served != hold_asks) begin
        served = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    rate_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        $error("result beat with no expectation pending");
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        check_field("rate_q8", want.rate, out_rate_q8);
        check_field("filtered_rate_q8", want.filtered, out_filtered_rate_q8);
        check_field("bias_q8", want.bias, out_bias_q8);
        check_field("last_raw", want.last_raw, out_last_raw);
        check_field("output_valid", want.out_ok, out_output_valid);
        check_field("device_present", want.present, out_device_present);
        check_field("calibrating", want.calibrating, out_calibrating);
        check_field("errors_seen", want.errors, out_errors_seen);
        check_field("samples_taken", want.samples, out_samples_taken);
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    write_register(CFG_ALPHA, 16'h7fff);
    write_register(CFG_NCAL, 16'd3);
    for (int i = 0; i < PLAN_ROWS; i++) begin
      send_gyro_cmd(plan[i].cmd, plan[i].typed, plan[i].want);
    end
    run_random_phase(31, 62, 16'h0000, 16'hff80, 1'b0);
    run_random_phase(62, 31, 16'hffff, 16'd127, 1'b0);
    run_random_phase(0, 0, 16'($urandom), 16'($urandom_range(8, 1)), 1'b1);
    drain_results();
    repeat (64) @(posedge clk);
    if (mismatches == 0) begin
      $display("gyro_rate_bias_ema_filter_core_test passed");
    end else begin
      $display("gyro_rate_bias_ema_filter_core_test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("gyro_rate_bias_ema_filter_core_test failed");
    $finish;
  end

endmodule
